// File: sv/icb_pkg.sv
// ----------------------------------------------------------------------------
// icb_pkg
// Shared constants and types of the ICMP source-count blocker.
// ----------------------------------------------------------------------------
package icb_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int CNT_W   = 16;

    // stream widths: slave tdata = {protocol, src_addr}, tuser = req_type
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    // master tdata = new_count, tuser = {table_full, found, drop}
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 3;

    // constants
    localparam logic [CNT_W-1:0]   THRESHOLD_RESET = 16'd5;
    localparam logic [CNT_W-1:0]   COUNT_MAX       = 16'hFFFF;
    localparam logic [PROTO_W-1:0] PROTO_ICMP      = 8'd1;

    // request kinds
    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;  // capture an input beat
        logic exec;     // look up, update the table, load the result
    } icb_cmd_t;

endpackage

// File: sv/icb_ctrl.sv
// ----------------------------------------------------------------------------
// icb_ctrl
// Sequencer: takes one beat, runs it through the datapath, holds the
// result valid until the receiver takes it.
// ----------------------------------------------------------------------------
module icb_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output icb_pkg::icb_cmd_t cmd
);
    import icb_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.load_in = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec    = (state_reg == ST_EXEC) && out_free;

    // next state and result valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/icb_dp.sv
// ----------------------------------------------------------------------------
// icb_dp
// Datapath: input registers, source table with parallel match, counter
// update, threshold register and result registers.
// ----------------------------------------------------------------------------
module icb_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  icb_pkg::icb_cmd_t             cmd,
    input  logic                          in_req_type,
    input  logic [icb_pkg::ADDR_W-1:0]    in_src_addr,
    input  logic [icb_pkg::PROTO_W-1:0]   in_protocol,
    input  logic                          cfg_we,
    input  logic [icb_pkg::CNT_W-1:0]     cfg_data,
    output logic                          out_drop,
    output logic                          out_found,
    output logic                          out_table_full,
    output logic [icb_pkg::CNT_W-1:0]     out_new_count
);
    import icb_pkg::*;

    // captured request
    logic               req_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [PROTO_W-1:0] proto_reg;

    // source table
    logic [ADDR_W-1:0]  entry_addr_reg  [TABLE_ENTRIES];
    logic [CNT_W-1:0]   entry_count_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] entry_valid_reg;

    logic [CNT_W-1:0]   threshold_reg;

    // result registers
    logic               drop_reg, found_reg, full_reg;
    logic [CNT_W-1:0]   count_reg;

    // lookup
    logic               hit, free_any;
    logic [IDX_W-1:0]   hit_idx, free_idx, slot_idx;
    logic [CNT_W-1:0]   cur_count, inc_count;
    logic               is_icmp, is_delete;
    logic               wr_en, ins_en;
    logic [CNT_W-1:0]   wr_count;
    logic               drop_next, found_next, full_next;
    logic [CNT_W-1:0]   count_next;

    // lowest matching slot and lowest free slot
    always_comb
    begin
        hit      = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (entry_valid_reg[i] && (entry_addr_reg[i] == addr_reg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!entry_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign is_delete = (req_reg == REQ_DELETE);
    assign is_icmp   = (req_reg == REQ_PACKET) && (proto_reg == PROTO_ICMP);
    assign slot_idx  = hit ? hit_idx : free_idx;
    // a new source starts from zero
    assign cur_count = hit ? entry_count_reg[hit_idx] : '0;
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + CNT_W'(1);

    // result and table update
    always_comb
    begin
        drop_next  = 1'b0;
        found_next = 1'b0;
        full_next  = 1'b0;
        count_next = '0;
        wr_en      = 1'b0;
        ins_en     = 1'b0;
        wr_count   = '0;
        if (is_delete)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                wr_en      = 1'b1;
            end
        end
        else if (is_icmp)
        begin
            if (hit || free_any)
            begin
                found_next = 1'b1;
                count_next = inc_count;
                drop_next  = (inc_count > threshold_reg);
                wr_en      = 1'b1;
                ins_en     = !hit;
                wr_count   = inc_count;
            end
            else
            begin
                full_next = 1'b1;
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg   <= in_req_type;
            addr_reg  <= in_src_addr;
            proto_reg <= in_protocol;
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            entry_count_reg[slot_idx] <= wr_count;
            if (ins_en)
            begin
                entry_addr_reg[slot_idx] <= addr_reg;
            end
        end
    end

    // valid bits and threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else
        begin
            if (cmd.exec && ins_en)
            begin
                entry_valid_reg[slot_idx] <= 1'b1;
            end
            if (cfg_we)
            begin
                threshold_reg <= cfg_data;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            drop_reg  <= drop_next;
            found_reg <= found_next;
            full_reg  <= full_next;
            count_reg <= count_next;
        end
    end

    assign out_drop       = drop_reg;
    assign out_found      = found_reg;
    assign out_table_full = full_reg;
    assign out_new_count  = count_reg;

endmodule

// File: sv/icmp_source_count_blocker.sv
// ----------------------------------------------------------------------------
// icmp_source_count_blocker
// Per-source ICMP packet counter with a drop threshold.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream : one beat per request. tuser holds req_type (0 = packet,
//                1 = delete); tdata holds src_addr and protocol.
//   m_* stream : one result beat per request. tuser holds drop, found and
//                table_full; tdata holds new_count.
//   cfg_*      : write of drop_threshold, always ready, one write per beat;
//                write only while no request is in flight.
//   Sequence   : the request beat is captured into the input registers, then the
//                parallel table match and counter update load the result
//                register; no new request is taken until then.
//   Reset      : all table entries become free and drop_threshold is 5.
//   Stall      : the result register holds while m_tready is low; the next
//                request is captured meanwhile and waits in its update
//                cycle until the result register drains.
// ----------------------------------------------------------------------------
module icmp_source_count_blocker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [icb_pkg::S_TDATA_W-1:0]    s_tdata,  // src_addr[31:0], protocol[39:32]
    input  logic [icb_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [icb_pkg::M_TDATA_W-1:0]    m_tdata,  // new_count[15:0]
    output logic [icb_pkg::M_TUSER_W-1:0]    m_tuser,  // drop[0], found[1], table_full[2]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [icb_pkg::CNT_W-1:0]        cfg_data  // drop_threshold
);
    import icb_pkg::*;

    icb_cmd_t cmd;
    logic     drop, found, table_full;

    assign cfg_ready = 1'b1;

    // sequencer
    icb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // table and result datapath
    icb_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_req_type    (s_tuser[0]),
        .in_src_addr    (s_tdata[ADDR_W-1:0]),
        .in_protocol    (s_tdata[ADDR_W+PROTO_W-1:ADDR_W]),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .out_drop       (drop),
        .out_found      (found),
        .out_table_full (table_full),
        .out_new_count  (m_tdata)
    );

    assign m_tuser = {table_full, found, drop};

endmodule

// File: tb/icmp_source_count_blocker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icmp_source_count_blocker_tb
// Self-checking regression for the ICMP source-count blocker.
// A scoreboard keeps its own copy of the source table and the drop
// threshold. Each request beat taken by the block updates that copy and
// queues the verdict it implies. Result beats are compared field by field
// against the queue in order. Stimulus is a short directed sweep, then a
// short run at the highest threshold, then random traffic over a small
// address pool at several thresholds. Both stream sides idle in random
// bursts while idling is enabled.
// ----------------------------------------------------------------------------
module icmp_source_count_blocker_tb;

    import icb_pkg::*;

    localparam int POOL_SIZE = 24;

    // one verdict per request beat
    typedef struct packed {
        logic             drop;
        logic             found;
        logic             table_full;
        logic [CNT_W-1:0] new_count;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the source table and checks result beats
    // ------------------------------------------------------------------------
    class source_count_scoreboard;
        logic [ADDR_W-1:0] slot_addr [TABLE_ENTRIES];
        logic [CNT_W-1:0]  slot_count[TABLE_ENTRIES];
        bit                slot_used [TABLE_ENTRIES];
        logic [CNT_W-1:0]  threshold;
        verdict_t          verdict_q[$];
        int                failures;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            threshold = THRESHOLD_RESET;
            failures  = 0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        // update the table copy for one accepted request, queue its verdict
        function void note_request(logic req, logic [ADDR_W-1:0] addr,
                                   logic [PROTO_W-1:0] proto);
            verdict_t v;
            int       slot;
            v    = '0;
            slot = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (slot < 0 && slot_used[i] && slot_addr[i] == addr)
                    slot = i;
            end
            if (req == REQ_DELETE)
            begin
                // delete keeps the entry, only clears its count
                if (slot >= 0)
                begin
                    slot_count[slot] = '0;
                    v.found = 1'b1;
                end
            end
            else if (proto == PROTO_ICMP)
            begin
                // new source goes to the lowest free slot
                if (slot < 0)
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (slot < 0 && !slot_used[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        slot_addr[slot]  = addr;
                        slot_count[slot] = '0;
                        slot_used[slot]  = 1'b1;
                    end
                end
                if (slot < 0)
                    v.table_full = 1'b1;
                else
                begin
                    if (slot_count[slot] != COUNT_MAX)
                        slot_count[slot] = slot_count[slot] + CNT_W'(1);
                    v.found     = 1'b1;
                    v.new_count = slot_count[slot];
                    v.drop      = (slot_count[slot] > threshold);
                end
            end
            verdict_q.push_back(v);
        endfunction

        // compare one result beat with the oldest queued verdict
        function void check_verdict(logic [M_TDATA_W-1:0] tdata,
                                    logic [M_TUSER_W-1:0] tuser);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no request outstanding: tdata=%h tuser=%b",
                       tdata, tuser);
                failures++;
                return;
            end
            want = verdict_q.pop_front();
            if (tuser[0] !== want.drop)
            begin
                $error("drop: expected %0d, got %0d", want.drop, tuser[0]);
                failures++;
            end
            if (tuser[1] !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, tuser[1]);
                failures++;
            end
            if (tuser[2] !== want.table_full)
            begin
                $error("table_full: expected %0d, got %0d", want.table_full, tuser[2]);
                failures++;
            end
            if (tdata !== want.new_count)
            begin
                $error("new_count: expected %0d, got %0d", want.new_count, tdata);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // src_addr[31:0], protocol[39:32]
    logic [S_TUSER_W-1:0] s_tuser   = '0;  // req_type[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;         // new_count[15:0]
    logic [M_TUSER_W-1:0] m_tuser;         // drop[0], found[1], table_full[2]
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data  = '0;

    bit                   idle_en   = 1'b1;
    logic [ADDR_W-1:0]    addr_pool[POOL_SIZE];

    source_count_scoreboard tally = new();

    icmp_source_count_blocker DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random backpressure bursts while idling is enabled
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tally.check_verdict(m_tdata, m_tuser);
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("icmp_source_count_blocker regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // one request beat; valid stays high unless a gap follows
    task automatic push_request(logic req, logic [ADDR_W-1:0] addr,
                                logic [PROTO_W-1:0] proto);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {proto, addr};
        do
            @(posedge clk);
        while (!s_tready);
        tally.note_request(req, addr, proto);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // let all results drain, then write the threshold
    task automatic write_threshold(logic [CNT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tally.threshold = value;
    endtask

    // random traffic over the address pool
    task automatic random_traffic(int n_items);
        int                 pick;
        logic [ADDR_W-1:0]  addr;
        logic [PROTO_W-1:0] proto;
        for (int n = 0; n < n_items; n++)
        begin
            pick  = $urandom_range(0, 99);
            addr  = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            proto = PROTO_W'($urandom_range(0, 255));
            if (pick < 10)
                push_request(REQ_DELETE, addr, proto);
            else if (pick < 14)
                push_request(REQ_DELETE, $urandom, proto);
            else if (pick < 20)
                push_request(REQ_PACKET, addr, proto);
            else if (pick < 24)
                push_request(REQ_PACKET, $urandom, proto);
            else if (pick < 28)
                push_request(REQ_PACKET, $urandom, PROTO_ICMP);
            else
                push_request(REQ_PACKET, addr, PROTO_ICMP);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CNT_W-1:0] phase_threshold[6];

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        phase_threshold[0] = '0;
        phase_threshold[1] = 16'd3;
        phase_threshold[2] = CNT_W'($urandom_range(2, 40));
        phase_threshold[3] = CNT_W'($urandom_range(0, 65535));
        phase_threshold[4] = 16'd1;
        phase_threshold[5] = CNT_W'($urandom_range(2, 12));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: non-ICMP packets and a delete of an unknown source
        push_request(REQ_PACKET, '0, 8'h00);
        push_request(REQ_PACKET, '1, 8'hFF);
        push_request(REQ_DELETE, 32'h0A00_0001, PROTO_ICMP);
        // one source past the reset threshold
        repeat (7) push_request(REQ_PACKET, addr_pool[0], PROTO_ICMP);
        push_request(REQ_PACKET, addr_pool[1], PROTO_ICMP);
        // delete of a known source, then it counts again from one
        push_request(REQ_DELETE, addr_pool[0], 8'hFF);
        push_request(REQ_PACKET, addr_pool[0], PROTO_ICMP);
        // fill the table, then one new source that finds no slot
        for (int i = 2; i < TABLE_ENTRIES; i++)
            push_request(REQ_PACKET, addr_pool[i], PROTO_ICMP);
        push_request(REQ_PACKET, addr_pool[TABLE_ENTRIES], PROTO_ICMP);

        // short run at the highest threshold, no idling
        idle_en = 1'b0;
        write_threshold('1);
        repeat (20) push_request(REQ_PACKET, addr_pool[2], PROTO_ICMP);
        push_request(REQ_DELETE, addr_pool[2], PROTO_ICMP);

        // random phases; every third runs without idling, the last one too
        for (int p = 0; p < 6; p++)
        begin
            idle_en = (p % 3 != 2) && (p != 5);
            write_threshold(phase_threshold[p]);
            random_traffic(200);
        end

        // drain and finish
        s_tvalid <= 1'b0;
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tally.failures == 0)
            $display("icmp_source_count_blocker regression: pass");
        else
            $display("icmp_source_count_blocker regression: fail");
        $finish;
    end

endmodule

// File: icmp_source_count_blocker.f
sv/icb_pkg.sv
sv/icb_ctrl.sv
sv/icb_dp.sv
sv/icmp_source_count_blocker.sv
tb/icmp_source_count_blocker_tb.sv
